### rtl/core/ufs_pkg.sv
// Shared types and constants for the union-find-by-size block.
// Used by the channel interfaces, the controller, the datapath and the top level.
package ufs_pkg;

  localparam int NODE_W  = 10;
  localparam int COUNT_W = 11;
  localparam int CMD_W   = 2;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 11'd1024;

  localparam logic [CMD_W-1:0] CMD_UNION = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef logic [3:0] dp_op_t;

  localparam dp_op_t OP_NOP      = 4'd0;
  localparam dp_op_t OP_LOAD     = 4'd1;
  localparam dp_op_t OP_WALK     = 4'd2;
  localparam dp_op_t OP_HALVE    = 4'd3;
  localparam dp_op_t OP_ROOT_A   = 4'd4;
  localparam dp_op_t OP_ROOT_B   = 4'd5;
  localparam dp_op_t OP_SIZE_A   = 4'd6;
  localparam dp_op_t OP_MERGE    = 4'd7;
  localparam dp_op_t OP_CLR_STEP = 4'd8;
  localparam dp_op_t OP_RESULT   = 4'd9;

  typedef struct packed {
    dp_op_t op;
  } ufs_cmd_t;

  typedef struct packed {
    logic in_err;
    logic is_root;
    logic same;
    logic clr_last;
    logic out_free;
  } ufs_stat_t;

endpackage

### rtl/core/ufs_if.sv
// Valid/ready channel interfaces for the request, result and configuration ports.
// Depends on ufs_pkg for field widths.
interface ufs_in_if import ufs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  modport source (output valid, cmd, node_a, node_b, input ready);
  modport sink   (input valid, cmd, node_a, node_b, output ready);
endinterface

interface ufs_out_if import ufs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               same_set;
  logic [NODE_W-1:0]  root_a;
  logic [NODE_W-1:0]  root_b;
  logic [COUNT_W-1:0] set_count;
  logic               index_error;
  modport source (output valid, same_set, root_a, root_b, set_count, index_error,
                  input ready);
  modport sink   (input valid, same_set, root_a, root_b, set_count, index_error,
                  output ready);
endinterface

interface ufs_cfg_if import ufs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] node_count;
  modport source (output valid, node_count, input ready);
  modport sink   (input valid, node_count, output ready);
endinterface

### rtl/core/ufs_ctrl.sv
// Sequencer for the union-find block: steps the datapath through root walks,
// merge and the clearing sweep. Depends on ufs_pkg.
module ufs_ctrl import ufs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  input  ufs_stat_t        stat,
  output ufs_cmd_t         dp_cmd
);

  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_FIND   = 3'd2;
  localparam logic [2:0] S_HALVE  = 3'd3;
  localparam logic [2:0] S_SIZE   = 3'd4;
  localparam logic [2:0] S_MERGE  = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic             second_r, second_nxt;
  logic             clr_reply_r, clr_reply_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    second_nxt    = second_r;
    clr_reply_nxt = clr_reply_r;
    dp_cmd.op     = OP_NOP;
    in_ready      = 1'b0;
    case (state_r)
      S_CLR: begin
        dp_cmd.op = OP_CLR_STEP;
        if (stat.clr_last) begin
          state_nxt = clr_reply_r ? S_RESULT : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.op  = OP_LOAD;
          cmd_nxt    = in_cmd;
          second_nxt = 1'b0;
          case (in_cmd)
            CMD_CLEAR: begin
              clr_reply_nxt = 1'b1;
              state_nxt     = S_CLR;
            end
            CMD_UNION, CMD_QUERY: begin
              state_nxt = stat.in_err ? S_RESULT : S_FIND;
            end
            default: begin
              state_nxt = S_RESULT;
            end
          endcase
        end
      end
      S_FIND: begin
        if (!stat.is_root) begin
          dp_cmd.op = OP_WALK;
          state_nxt = S_HALVE;
        end else if (!second_r) begin
          // first root known; start the walk from the second element
          dp_cmd.op  = OP_ROOT_A;
          second_nxt = 1'b1;
        end else begin
          dp_cmd.op = OP_ROOT_B;
          state_nxt = (cmd_r == CMD_QUERY || stat.same) ? S_RESULT : S_SIZE;
        end
      end
      S_HALVE: begin
        dp_cmd.op = OP_HALVE;
        state_nxt = S_FIND;
      end
      S_SIZE: begin
        dp_cmd.op = OP_SIZE_A;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        dp_cmd.op = OP_MERGE;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        // hold until the output register is free
        if (stat.out_free) begin
          dp_cmd.op     = OP_RESULT;
          clr_reply_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cmd_r       <= CMD_UNION;
      second_r    <= 1'b0;
      clr_reply_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      second_r    <= second_nxt;
      clr_reply_r <= clr_reply_nxt;
    end
  end

endmodule

### rtl/core/ufs_datapath.sv
// Datapath of the union-find block: parent and size memories, walk registers,
// set counter, node count register and the result register. Depends on ufs_pkg.
module ufs_datapath import ufs_pkg::*; #(
  parameter int MAX_NODES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ufs_cmd_t           dp_cmd,
  output ufs_stat_t          stat,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [NODE_W-1:0]  in_node_a,
  input  logic [NODE_W-1:0]  in_node_b,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_node_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_same_set,
  output logic [NODE_W-1:0]  out_root_a,
  output logic [NODE_W-1:0]  out_root_b,
  output logic [COUNT_W-1:0] out_set_count,
  output logic               out_index_error
);

  localparam int AW       = $clog2(MAX_NODES);
  localparam int SW       = $clog2(MAX_NODES + 1);
  localparam int MAXN_CAP = (MAX_NODES > 2047) ? 2047 : MAX_NODES;
  localparam logic [COUNT_W-1:0] MAXN_C    = COUNT_W'(MAXN_CAP);
  localparam logic [AW-1:0]      LAST_NODE = AW'(MAX_NODES - 1);

  logic [AW-1:0] parent_mem [MAX_NODES];
  logic [SW-1:0] size_mem   [MAX_NODES];

  logic [AW-1:0]      prd_r;
  logic [SW-1:0]      srd_r;
  logic [AW-1:0]      x_r, b_r, ra_r, rb_r, clr_cnt_r;
  logic [SW-1:0]      sa_r;
  logic               same_r, err_r;
  logic [COUNT_W-1:0] sets_r, node_count_r, eff_count;
  logic               out_valid_r, out_same_r, out_err_r;
  logic [NODE_W-1:0]  out_ra_r, out_rb_r;
  logic [COUNT_W-1:0] out_sets_r;

  logic [AW-1:0] p_raddr, p_waddr, p_wdata;
  logic          p_we;
  logic [AW-1:0] s_raddr, s_waddr;
  logic [SW-1:0] s_wdata;
  logic          s_we;
  logic          a_wins;
  logic [AW-1:0] winner, loser;

  assign eff_count = (node_count_r > MAXN_C) ? MAXN_C : node_count_r;

  assign stat.in_err   = ({1'b0, in_node_a} >= eff_count) || ({1'b0, in_node_b} >= eff_count);
  assign stat.is_root  = (prd_r == x_r);
  assign stat.same     = (ra_r == x_r);
  assign stat.clr_last = (clr_cnt_r == LAST_NODE);
  assign stat.out_free = !out_valid_r || out_ready;

  // larger tree wins; on a tie the first root goes under the second
  assign a_wins = (sa_r > srd_r);
  assign winner = a_wins ? ra_r : rb_r;
  assign loser  = a_wins ? rb_r : ra_r;

  always_comb begin
    p_raddr = x_r;
    p_we    = 1'b0;
    p_waddr = x_r;
    p_wdata = prd_r;
    s_raddr = ra_r;
    s_we    = 1'b0;
    s_waddr = winner;
    s_wdata = SW'(sa_r + srd_r);
    case (dp_cmd.op)
      OP_LOAD:   p_raddr = AW'(in_node_a);
      OP_WALK:   p_raddr = prd_r;
      OP_HALVE: begin
        // relink to the grandparent and advance to it
        p_we    = 1'b1;
        p_raddr = prd_r;
      end
      OP_ROOT_A: p_raddr = b_r;
      OP_ROOT_B: s_raddr = ra_r;
      OP_SIZE_A: s_raddr = rb_r;
      OP_MERGE: begin
        p_we    = 1'b1;
        p_waddr = loser;
        p_wdata = winner;
        s_we    = 1'b1;
      end
      OP_CLR_STEP: begin
        p_we    = 1'b1;
        p_waddr = clr_cnt_r;
        p_wdata = clr_cnt_r;
        s_we    = 1'b1;
        s_waddr = clr_cnt_r;
        s_wdata = SW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      parent_mem[p_waddr] <= p_wdata;
    end
    prd_r <= parent_mem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      size_mem[s_waddr] <= s_wdata;
    end
    srd_r <= size_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    case (dp_cmd.op)
      OP_LOAD: begin
        x_r    <= AW'(in_node_a);
        b_r    <= AW'(in_node_b);
        ra_r   <= '0;
        rb_r   <= '0;
        same_r <= 1'b0;
        err_r  <= stat.in_err && (in_cmd == CMD_UNION || in_cmd == CMD_QUERY);
      end
      OP_HALVE:  x_r <= prd_r;
      OP_ROOT_A: begin
        ra_r <= x_r;
        x_r  <= b_r;
      end
      OP_ROOT_B: begin
        rb_r   <= x_r;
        same_r <= stat.same;
      end
      OP_SIZE_A: sa_r <= srd_r;
      default: begin
      end
    endcase
    if (dp_cmd.op == OP_RESULT) begin
      out_same_r <= same_r;
      out_ra_r   <= NODE_W'(ra_r);
      out_rb_r   <= NODE_W'(rb_r);
      out_sets_r <= sets_r;
      out_err_r  <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r    <= '0;
      sets_r       <= '0;
      node_count_r <= NODE_COUNT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_node_count;
      end
      if (dp_cmd.op == OP_CLR_STEP) begin
        clr_cnt_r <= stat.clr_last ? '0 : clr_cnt_r + 1'b1;
        if (stat.clr_last) begin
          sets_r <= eff_count;
        end
      end
      if (dp_cmd.op == OP_MERGE && sets_r != '0) begin
        sets_r <= sets_r - 1'b1;
      end
      if (dp_cmd.op == OP_RESULT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_same_set    = out_same_r;
  assign out_root_a      = out_ra_r;
  assign out_root_b      = out_rb_r;
  assign out_set_count   = out_sets_r;
  assign out_index_error = out_err_r;

endmodule

### rtl/core/union_find_by_size.sv
// Disjoint-set store over MAX_NODES elements with union by size and path halving.
// A union or query request walks two roots in turn on one parent memory with a read and
// a write port, with a read step and a halving write step per link followed; a union that
// merges then reads both sizes and writes the link. A request with a bad index or an
// unused command goes straight to the result. A clear request and the pass after reset
// sweep all MAX_NODES entries of the memories one entry a cycle, with in_ch.ready low.
// One request is in flight at a time; a finished result waits in the output register.
// node_count (cfg_ch) may be written only while the block is idle.
module union_find_by_size import ufs_pkg::*; #(
  parameter int MAX_NODES = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  ufs_in_if.sink    in_ch,
  ufs_out_if.source out_ch,
  ufs_cfg_if.sink   cfg_ch
);

  ufs_cmd_t  dp_cmd;
  ufs_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  ufs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .dp_cmd   (dp_cmd)
  );

  ufs_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .dp_cmd          (dp_cmd),
    .stat            (stat),
    .in_cmd          (in_ch.cmd),
    .in_node_a       (in_ch.node_a),
    .in_node_b       (in_ch.node_b),
    .cfg_we          (cfg_ch.valid),
    .cfg_node_count  (cfg_ch.node_count),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_same_set    (out_ch.same_set),
    .out_root_a      (out_ch.root_a),
    .out_root_b      (out_ch.root_b),
    .out_set_count   (out_ch.set_count),
    .out_index_error (out_ch.index_error)
  );

endmodule
